// ===== hw/rtl/scsd_pkg.sv =====
// shared types, constants and the micro-op table of the skin cell split decider
package scsd_pkg;

    // fixed field widths
    localparam int CH_W        = 8;
    localparam int RES_CNT_W   = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int RATIO_W     = 10;
    localparam int HIST_BINS   = 256;
    localparam int BIN_W       = 8;

    // cell size bound
    localparam int DEF_MAX_CELL_PIXELS = 65536;

    // multi-word arithmetic: 12 limbs of 32 bits
    localparam int LIMB_W = 32;
    localparam int NLIMB  = 12;
    localparam int LIDX_W = 4;
    localparam int BIG_W  = LIMB_W * NLIMB;

    // intensity = floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PERMILLE   = 1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 3'd4;

    // register reset values
    localparam logic [RATIO_W-1:0] RST_RATIO  = 10'd350;
    localparam logic [CH_W-1:0]    RST_RED    = 8'd95;
    localparam logic [CH_W-1:0]    RST_GREEN  = 8'd40;
    localparam logic [CH_W-1:0]    RST_BLUE   = 8'd20;
    localparam logic [CH_W-1:0]    RST_SPREAD = 8'd15;

    // pixel transaction
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last_pixel;
    } t_pix;

    // result transaction
    typedef struct packed {
        logic                 split;
        logic [RES_CNT_W-1:0] skin_count;
        logic [RES_CNT_W-1:0] pixel_count;
        logic                 zero_variance;
    } t_res;

    // operand sources of the shared multiply-accumulate unit
    typedef enum logic [3:0] {
        SRC_G0, SRC_G1, SRC_G2, SRC_G3, SRC_G4, SRC_G5, SRC_G6, SRC_G7,
        SRC_ACUR, SRC_BCUR, SRC_D, SRC_H, SRC_P, SRC_S, SRC_C3
    } t_src;

    // one micro-op: dst (+)= x * y, x and y given with their limb counts
    typedef struct packed {
        t_src       dst;
        t_src       x;
        logic [2:0] nx;
        t_src       y;
        logic [2:0] ny;
        logic       clr;
    } t_op;

    localparam logic [3:0] OP_BIN_FIRST  = 4'd0;
    localparam logic [3:0] OP_BIN_LAST   = 4'd3;
    localparam logic [3:0] OP_POST_FIRST = 4'd4;
    localparam logic [3:0] OP_POST_LAST  = 4'd9;
    localparam logic [3:0] OP_FIN_FIRST  = 4'd10;
    localparam logic [3:0] OP_FIN_LAST   = 4'd11;

    // accumulator of the running pass: total pass uses g0/g1, skin pass g2/g3
    function automatic t_src src_resolve(t_src s, logic pass);
        t_src r;
        case (s)
            SRC_ACUR: r = pass ? SRC_G2 : SRC_G0;
            SRC_BCUR: r = pass ? SRC_G3 : SRC_G1;
            default:  r = s;
        endcase
        return r;
    endfunction

    // micro-op program
    //   per bin: g4 = d*d, g5 = h*g4, A += h*g4, B += g5*g4
    //   post:    g4 = bt*p, g5 = bs*s, g6 = at^2, g7 = as^2, g1 = 3*g6, g3 = 3*g7
    //   final:   g0 = g5*g6, g2 = g4*g7
    function automatic t_op op_at(logic [3:0] idx);
        t_op o;
        case (idx)
            4'd0:    o = '{dst: SRC_G4, x: SRC_D, nx: 3'd1, y: SRC_D, ny: 3'd1, clr: 1'b1};
            4'd1:    o = '{dst: SRC_G5, x: SRC_H, nx: 3'd1, y: SRC_G4, ny: 3'd2, clr: 1'b1};
            4'd2:    o = '{dst: SRC_ACUR, x: SRC_H, nx: 3'd1, y: SRC_G4, ny: 3'd2, clr: 1'b0};
            4'd3:    o = '{dst: SRC_BCUR, x: SRC_G5, nx: 3'd3, y: SRC_G4, ny: 3'd2, clr: 1'b0};
            4'd4:    o = '{dst: SRC_G4, x: SRC_G1, nx: 3'd5, y: SRC_P, ny: 3'd1, clr: 1'b1};
            4'd5:    o = '{dst: SRC_G5, x: SRC_G3, nx: 3'd5, y: SRC_S, ny: 3'd1, clr: 1'b1};
            4'd6:    o = '{dst: SRC_G6, x: SRC_G0, nx: 3'd3, y: SRC_G0, ny: 3'd3, clr: 1'b1};
            4'd7:    o = '{dst: SRC_G7, x: SRC_G2, nx: 3'd3, y: SRC_G2, ny: 3'd3, clr: 1'b1};
            4'd8:    o = '{dst: SRC_G1, x: SRC_G6, nx: 3'd5, y: SRC_C3, ny: 3'd1, clr: 1'b1};
            4'd9:    o = '{dst: SRC_G3, x: SRC_G7, nx: 3'd5, y: SRC_C3, ny: 3'd1, clr: 1'b1};
            4'd10:   o = '{dst: SRC_G0, x: SRC_G5, nx: 3'd5, y: SRC_G6, ny: 3'd5, clr: 1'b1};
            4'd11:   o = '{dst: SRC_G2, x: SRC_G4, nx: 3'd5, y: SRC_G7, ny: 3'd5, clr: 1'b1};
            default: o = '{dst: SRC_G4, x: SRC_D, nx: 3'd1, y: SRC_D, ny: 3'd1, clr: 1'b1};
        endcase
        return o;
    endfunction

endpackage

// ===== hw/rtl/skin_cell_split_decider_core.sv =====
// top level: skin cell split decider with histogram and shared multi-word mac unit
//
// Pixels of one image cell arrive on the input channel (valid/ready), the final
// pixel marked by last_pixel. Each pixel is tested against the RGB skin rule,
// counted, and its intensity is added to a 256-bin histogram memory; a pixel is
// accepted and then written back by a histogram read-modify-write before the
// next one is taken. Pixels beyond MAX_CELL_PIXELS are dropped.
// The marked pixel starts the end pass: two sweeps over the 256 bins compute
// the central moment sums with one 32x32 multiply-accumulate unit working limb
// by limb on 384-bit words, then a few wide products and limb-serial compares
// settle the decision. The moment sweeps are skipped when no skin was seen.
// The block takes no pixel during the end pass. One result transaction per
// cell leaves through an output register; a pending result does not block new
// pixels, and only the next cell's result waits while the receiver stalls.
// Reset (i_rst_n low at a clock edge) empties the histogram through per-bin
// valid bits, clears the counters and loads the register defaults.
// Configuration writes take effect at once; they are to be made while the block
// idles, which the user must see to, as the block itself does not enforce it.
module skin_cell_split_decider_core #(
    parameter int MAX_CELL_PIXELS = scsd_pkg::DEF_MAX_CELL_PIXELS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  scsd_pkg::t_pix                     i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output scsd_pkg::t_res                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [scsd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [scsd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import scsd_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELL_PIXELS + 1);
    localparam int NK_W  = CNT_W + BIN_W;
    localparam int RC_W  = CNT_W + RATIO_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CELL_PIXELS);

    typedef enum logic [3:0] {
        S_IDLE, S_WR, S_RATIO, S_INIT, S_HRD, S_HGET, S_OCLR, S_OMAC,
        S_NEXTBIN, S_ZCHK, S_CMP, S_EMIT
    } t_state;

    typedef enum logic [1:0] {GRP_BIN, GRP_POST, GRP_FIN} t_grp;
    typedef enum logic [1:0] {CMP_Y, CMP_X, CMP_K} t_csel;

    t_state r_state;
    t_grp   r_grp;
    t_csel  r_csel;

    // configuration registers
    logic [RATIO_W-1:0] r_ratio;
    logic [CH_W-1:0]    r_rmin, r_gmin, r_bmin, r_spread;

    // pixel stage
    logic             r_skin, r_last, r_take;
    logic [BIN_W-1:0] r_bin;
    logic [CNT_W-1:0] r_pix_cnt, r_skin_cnt;
    logic [NK_W-1:0]  r_m1;

    // histogram memory with per-bin valid bits
    logic [CNT_W-1:0]     r_hist [HIST_BINS];
    logic [HIST_BINS-1:0] r_hv;
    logic [CNT_W-1:0]     r_hrd;
    logic                 r_hvq;

    // end pass sequencing
    logic             r_pass;
    logic [BIN_W-1:0] r_k;
    logic [NK_W-1:0]  r_nk, r_d;
    logic [CNT_W-1:0] r_h;
    logic [3:0]       r_op, r_op_last;
    logic [LIDX_W-1:0] r_i, r_j, r_ci;
    logic [LIMB_W-1:0] r_carry;
    logic             r_ratio_ok, r_ysgn, r_split, r_zv;

    // wide work registers
    logic [BIG_W-1:0] r_g0, r_g1, r_g2, r_g3, r_g4, r_g5, r_g6, r_g7;

    // output register
    logic r_out_valid;
    t_res r_out;

    // pixel front end
    logic [CH_W-1:0]    w_mx, w_mn, w_rg;
    logic               w_skin;
    logic [BIN_W+1:0]   w_isum;
    logic [20:0]        w_iprod;
    logic [BIN_W-1:0]   w_bin;
    logic               w_in_acc;
    logic [BIN_W-1:0]   w_raddr;
    logic [CNT_W-1:0]   w_hval;

    // mac unit
    t_op               w_op;
    t_src              w_dst, w_xs, w_ys;
    logic [BIG_W-1:0]  w_xbig, w_ybig, w_dbig, w_ca_big, w_cb_big;
    logic [LIMB_W-1:0] w_xl, w_yl, w_rl, w_ca, w_cb;
    logic [2*LIMB_W-1:0] w_sum;
    logic [LIDX_W-1:0] w_idx;
    logic [LIDX_W:0]   w_idx5;
    logic              w_cont, w_row_last;
    logic [RC_W-1:0]   w_sk_scaled, w_px_scaled;
    logic              w_emit_go;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_emit_go   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // skin rule and intensity bin
    always_comb begin
        w_mx = (i_in_data.red > i_in_data.green) ? i_in_data.red : i_in_data.green;
        w_mn = (i_in_data.red < i_in_data.green) ? i_in_data.red : i_in_data.green;
        if (i_in_data.blue > w_mx) begin
            w_mx = i_in_data.blue;
        end
        if (i_in_data.blue < w_mn) begin
            w_mn = i_in_data.blue;
        end
        w_rg = (i_in_data.red > i_in_data.green) ? i_in_data.red - i_in_data.green
                                                 : i_in_data.green - i_in_data.red;
        w_skin = (i_in_data.red > r_rmin) && (i_in_data.green > r_gmin)
              && (i_in_data.blue > r_bmin) && ((w_mx - w_mn) > r_spread)
              && (w_rg > r_spread) && (i_in_data.red > i_in_data.green)
              && (i_in_data.red > i_in_data.blue);
        w_isum  = 10'(i_in_data.red) + 10'(i_in_data.green) + 10'(i_in_data.blue);
        w_iprod = 21'(w_isum) * 21'(DIV3_MUL);
        w_bin   = w_iprod[DIV3_SHIFT +: BIN_W];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio  <= RST_RATIO;
            r_rmin   <= RST_RED;
            r_gmin   <= RST_GREEN;
            r_bmin   <= RST_BLUE;
            r_spread <= RST_SPREAD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATIO:  r_ratio  <= i_cfg_wdata[RATIO_W-1:0];
                CFG_RED:    r_rmin   <= i_cfg_wdata[CH_W-1:0];
                CFG_GREEN:  r_gmin   <= i_cfg_wdata[CH_W-1:0];
                CFG_BLUE:   r_bmin   <= i_cfg_wdata[CH_W-1:0];
                CFG_SPREAD: r_spread <= i_cfg_wdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel latch
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_skin <= w_skin;
            r_bin  <= w_bin;
            r_last <= i_in_data.last_pixel;
            r_take <= (r_pix_cnt < MAX_CNT);
        end
    end

    // histogram memory: read at accept or during the bin sweep, write on update
    assign w_raddr = (r_state == S_IDLE) ? w_bin : r_k;
    assign w_hval  = r_hvq ? r_hrd : '0;

    always_ff @(posedge i_clk) begin
        r_hrd <= r_hist[w_raddr];
        if ((r_state == S_WR) && r_take) begin
            r_hist[r_bin] <= w_hval + CNT_W'(1);
        end
    end

    // cell counters and bin valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv       <= '0;
            r_hvq      <= 1'b0;
            r_pix_cnt  <= '0;
            r_skin_cnt <= '0;
            r_m1       <= '0;
        end else begin
            r_hvq <= r_hv[w_raddr];
            if (w_emit_go) begin
                r_hv       <= '0;
                r_pix_cnt  <= '0;
                r_skin_cnt <= '0;
                r_m1       <= '0;
            end else if ((r_state == S_WR) && r_take) begin
                r_hv[r_bin] <= 1'b1;
                r_pix_cnt   <= r_pix_cnt + CNT_W'(1);
                r_skin_cnt  <= r_skin_cnt + CNT_W'(r_skin);
                r_m1        <= r_m1 + NK_W'(r_bin);
            end
        end
    end

    // bin sweep datapath: n*k and |n*k - m1|
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_INIT: r_nk <= '0;
            S_HGET: begin
                r_h <= w_hval;
                r_d <= (r_nk >= r_m1) ? r_nk - r_m1 : r_m1 - r_nk;
            end
            S_NEXTBIN: begin
                if (r_k == BIN_W'(HIST_BINS - 1)) begin
                    r_nk <= '0;
                end else begin
                    r_nk <= r_nk + NK_W'(r_pass ? r_skin_cnt : r_pix_cnt);
                end
            end
            default: ;
        endcase
    end

    // operand selection for the mac unit and the comparator
    always_comb begin
        w_op  = op_at(r_op);
        w_dst = src_resolve(w_op.dst, r_pass);
        w_xs  = src_resolve(w_op.x, r_pass);
        w_ys  = src_resolve(w_op.y, r_pass);

        case (w_xs)
            SRC_G0:  w_xbig = r_g0;
            SRC_G1:  w_xbig = r_g1;
            SRC_G2:  w_xbig = r_g2;
            SRC_G3:  w_xbig = r_g3;
            SRC_G4:  w_xbig = r_g4;
            SRC_G5:  w_xbig = r_g5;
            SRC_G6:  w_xbig = r_g6;
            SRC_G7:  w_xbig = r_g7;
            SRC_D:   w_xbig = BIG_W'(r_d);
            SRC_H:   w_xbig = BIG_W'(r_h);
            SRC_P:   w_xbig = BIG_W'(r_pix_cnt);
            SRC_S:   w_xbig = BIG_W'(r_skin_cnt);
            SRC_C3:  w_xbig = BIG_W'(3);
            default: w_xbig = '0;
        endcase

        case (w_ys)
            SRC_G0:  w_ybig = r_g0;
            SRC_G1:  w_ybig = r_g1;
            SRC_G2:  w_ybig = r_g2;
            SRC_G3:  w_ybig = r_g3;
            SRC_G4:  w_ybig = r_g4;
            SRC_G5:  w_ybig = r_g5;
            SRC_G6:  w_ybig = r_g6;
            SRC_G7:  w_ybig = r_g7;
            SRC_D:   w_ybig = BIG_W'(r_d);
            SRC_H:   w_ybig = BIG_W'(r_h);
            SRC_P:   w_ybig = BIG_W'(r_pix_cnt);
            SRC_S:   w_ybig = BIG_W'(r_skin_cnt);
            SRC_C3:  w_ybig = BIG_W'(3);
            default: w_ybig = '0;
        endcase

        case (w_dst)
            SRC_G0:  w_dbig = r_g0;
            SRC_G1:  w_dbig = r_g1;
            SRC_G2:  w_dbig = r_g2;
            SRC_G3:  w_dbig = r_g3;
            SRC_G4:  w_dbig = r_g4;
            SRC_G5:  w_dbig = r_g5;
            SRC_G6:  w_dbig = r_g6;
            SRC_G7:  w_dbig = r_g7;
            default: w_dbig = '0;
        endcase

        case (r_csel)
            CMP_Y: begin
                w_ca_big = r_g4;
                w_cb_big = r_g1;
            end
            CMP_X: begin
                w_ca_big = r_g5;
                w_cb_big = r_g3;
            end
            CMP_K: begin
                w_ca_big = r_g0;
                w_cb_big = r_g2;
            end
            default: begin
                w_ca_big = '0;
                w_cb_big = '0;
            end
        endcase
    end

    // one limb step: sum = x[i] * y[j] + dst[i+j] + carry
    always_comb begin
        w_idx5     = (LIDX_W+1)'(r_i) + (LIDX_W+1)'(r_j);
        w_idx      = w_idx5[LIDX_W-1:0];
        w_xl       = w_xbig[LIMB_W*r_i +: LIMB_W];
        w_yl       = ((LIDX_W+1)'(r_j) < (LIDX_W+1)'(w_op.ny)) ?
                     w_ybig[LIMB_W*r_j +: LIMB_W] : '0;
        w_rl       = w_dbig[LIMB_W*w_idx +: LIMB_W];
        w_sum      = (2*LIMB_W)'(w_xl) * (2*LIMB_W)'(w_yl) + (2*LIMB_W)'(w_rl)
                   + (2*LIMB_W)'(r_carry);
        w_cont     = (((LIDX_W+1)'(r_j) + 1'b1 < (LIDX_W+1)'(w_op.ny))
                     || (w_sum[2*LIMB_W-1:LIMB_W] != '0))
                     && (w_idx5 + 1'b1 < (LIDX_W+1)'(NLIMB));
        w_row_last = ((LIDX_W+1)'(r_i) + 1'b1 == (LIDX_W+1)'(w_op.nx));
        w_ca       = w_ca_big[LIMB_W*r_ci +: LIMB_W];
        w_cb       = w_cb_big[LIMB_W*r_ci +: LIMB_W];
        w_sk_scaled = RC_W'(r_skin_cnt) * RC_W'(PERMILLE);
        w_px_scaled = RC_W'(r_ratio) * RC_W'(r_pix_cnt);
    end

    // wide work registers: clear and limb writes of the mac unit
    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT) begin
            r_g0 <= '0;
            r_g1 <= '0;
            r_g2 <= '0;
            r_g3 <= '0;
        end else if ((r_state == S_OCLR) && w_op.clr) begin
            case (w_dst)
                SRC_G0:  r_g0 <= '0;
                SRC_G1:  r_g1 <= '0;
                SRC_G2:  r_g2 <= '0;
                SRC_G3:  r_g3 <= '0;
                SRC_G4:  r_g4 <= '0;
                SRC_G5:  r_g5 <= '0;
                SRC_G6:  r_g6 <= '0;
                SRC_G7:  r_g7 <= '0;
                default: ;
            endcase
        end else if (r_state == S_OMAC) begin
            case (w_dst)
                SRC_G0:  r_g0[LIMB_W*w_idx +: LIMB_W] <= w_sum[LIMB_W-1:0];
                SRC_G1:  r_g1[LIMB_W*w_idx +: LIMB_W] <= w_sum[LIMB_W-1:0];
                SRC_G2:  r_g2[LIMB_W*w_idx +: LIMB_W] <= w_sum[LIMB_W-1:0];
                SRC_G3:  r_g3[LIMB_W*w_idx +: LIMB_W] <= w_sum[LIMB_W-1:0];
                SRC_G4:  r_g4[LIMB_W*w_idx +: LIMB_W] <= w_sum[LIMB_W-1:0];
                SRC_G5:  r_g5[LIMB_W*w_idx +: LIMB_W] <= w_sum[LIMB_W-1:0];
                SRC_G6:  r_g6[LIMB_W*w_idx +: LIMB_W] <= w_sum[LIMB_W-1:0];
                SRC_G7:  r_g7[LIMB_W*w_idx +: LIMB_W] <= w_sum[LIMB_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, decision and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_grp       <= GRP_BIN;
            r_csel      <= CMP_Y;
            r_pass      <= 1'b0;
            r_k         <= '0;
            r_op        <= OP_BIN_FIRST;
            r_op_last   <= OP_BIN_LAST;
            r_i         <= '0;
            r_j         <= '0;
            r_ci        <= '0;
            r_carry     <= '0;
            r_ratio_ok  <= 1'b0;
            r_ysgn      <= 1'b0;
            r_split     <= 1'b0;
            r_zv        <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_state <= r_last ? S_RATIO : S_IDLE;
                end
                // ratio test, then skip the moments when no skin was seen
                S_RATIO: begin
                    r_ratio_ok <= (w_sk_scaled >= w_px_scaled);
                    r_zv       <= 1'b0;
                    r_split    <= 1'b0;
                    r_pass     <= 1'b0;
                    r_state    <= (r_skin_cnt == '0) ? S_EMIT : S_INIT;
                end
                S_INIT: begin
                    r_k     <= '0;
                    r_state <= S_HRD;
                end
                S_HRD: begin
                    r_state <= S_HGET;
                end
                // empty bins add nothing
                S_HGET: begin
                    if (w_hval == '0) begin
                        r_state <= S_NEXTBIN;
                    end else begin
                        r_op      <= OP_BIN_FIRST;
                        r_op_last <= OP_BIN_LAST;
                        r_grp     <= GRP_BIN;
                        r_state   <= S_OCLR;
                    end
                end
                S_OCLR: begin
                    r_i     <= '0;
                    r_j     <= '0;
                    r_carry <= '0;
                    r_state <= S_OMAC;
                end
                // limb-serial multiply-accumulate, carry rippled past the y operand
                S_OMAC: begin
                    if (w_cont) begin
                        r_j     <= r_j + 1'b1;
                        r_carry <= w_sum[2*LIMB_W-1:LIMB_W];
                    end else begin
                        r_j     <= '0;
                        r_carry <= '0;
                        if (!w_row_last) begin
                            r_i <= r_i + 1'b1;
                        end else if (r_op != r_op_last) begin
                            r_op    <= r_op + 1'b1;
                            r_state <= S_OCLR;
                        end else begin
                            case (r_grp)
                                GRP_BIN: r_state <= S_NEXTBIN;
                                GRP_POST: begin
                                    r_csel  <= CMP_Y;
                                    r_ci    <= LIDX_W'(NLIMB - 1);
                                    r_state <= S_CMP;
                                end
                                GRP_FIN: begin
                                    r_csel  <= CMP_K;
                                    r_ci    <= LIDX_W'(NLIMB - 1);
                                    r_state <= S_CMP;
                                end
                                default: r_state <= S_NEXTBIN;
                            endcase
                        end
                    end
                end
                S_NEXTBIN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k != BIN_W'(HIST_BINS - 1)) begin
                        r_state <= S_HRD;
                    end else if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_state <= S_HRD;
                    end else begin
                        r_state <= S_ZCHK;
                    end
                end
                // a zero variance counts as a passing kurtosis ratio
                S_ZCHK: begin
                    if ((r_g0 == '0) || (r_g2 == '0)) begin
                        r_zv    <= 1'b1;
                        r_split <= r_ratio_ok;
                        r_state <= S_EMIT;
                    end else begin
                        r_op      <= OP_POST_FIRST;
                        r_op_last <= OP_POST_LAST;
                        r_grp     <= GRP_POST;
                        r_state   <= S_OCLR;
                    end
                end
                // compare from the top limb down, stop at the first difference
                S_CMP: begin
                    if ((w_ca == w_cb) && (r_ci != '0)) begin
                        r_ci <= r_ci - 1'b1;
                    end else begin
                        case (r_csel)
                            CMP_Y: begin
                                if (w_ca == w_cb) begin
                                    r_csel <= CMP_X;
                                    r_ci   <= LIDX_W'(NLIMB - 1);
                                end else begin
                                    r_ysgn    <= (w_ca > w_cb);
                                    r_op      <= OP_FIN_FIRST;
                                    r_op_last <= OP_FIN_LAST;
                                    r_grp     <= GRP_FIN;
                                    r_state   <= S_OCLR;
                                end
                            end
                            CMP_X: begin
                                r_split <= r_ratio_ok && (w_ca > w_cb);
                                r_state <= S_EMIT;
                            end
                            CMP_K: begin
                                r_split <= r_ratio_ok && (r_ysgn ? (w_ca >= w_cb)
                                                                 : (w_ca <= w_cb));
                                r_state <= S_EMIT;
                            end
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (w_emit_go) begin
                        r_out_valid         <= 1'b1;
                        r_out.split         <= r_split;
                        r_out.skin_count    <= RES_CNT_W'(r_skin_cnt);
                        r_out.pixel_count   <= RES_CNT_W'(r_pix_cnt);
                        r_out.zero_variance <= r_zv;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
